/* sv/kpsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kpsd_pkg;

	localparam int ROWS     = 6;
	localparam int SENSE_W  = 4;
	localparam int CODE_W   = 5;
	localparam int COUNT_W  = 8;
	localparam int COL_W    = 2;

	localparam logic [SENSE_W-1:0] SENSE_NONE = 4'hF;
	localparam logic [SENSE_W-1:0] SENSE_COL0 = 4'hE;
	localparam logic [SENSE_W-1:0] SENSE_COL1 = 4'hD;
	localparam logic [SENSE_W-1:0] SENSE_COL2 = 4'hB;
	localparam logic [SENSE_W-1:0] SENSE_COL3 = 4'h7;

	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd3;
	localparam logic [CODE_W-1:0]  CODE_NONE      = '0;
	localparam logic [CODE_W-1:0]  CODE_MAX       = 5'd24;

	typedef logic [ROWS-1:0][SENSE_W-1:0] row_sense_t;
	typedef logic [CODE_W-1:0]            code_t;
	typedef logic [COUNT_W-1:0]           count_t;

	typedef struct packed {
		logic   release_phase;
		count_t tick_count;
	} deb_status_t;

endpackage

`default_nettype wire

/* sv/kpsd_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module kpsd_decode (
	input  wire logic [kpsd_pkg::SENSE_W-1:0] idle_sense,
	input  wire kpsd_pkg::row_sense_t         row_sense,
	output kpsd_pkg::code_t                   code
);
	import kpsd_pkg::*;

	logic [COL_W-1:0] col;
	logic [3:0]       row;
	logic [7:0]       sum;

	always_comb begin
		unique case (idle_sense)
			SENSE_COL1: col = 2'd1;
			SENSE_COL2: col = 2'd2;
			SENSE_COL3: col = 2'd3;
			default:    col = 2'd0;
		endcase
	end

	// Walk from the last row down so that the first low row wins.
	always_comb begin
		row = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (row_sense[i] != SENSE_NONE) begin
				row = 4'(i + 1);
			end
		end
	end

	assign sum = 8'(col * ROWS) + {4'd0, row};

	always_comb begin
		if (idle_sense == SENSE_NONE) begin
			code = CODE_NONE;
		end else begin
			code = sum[CODE_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* sv/kpsd_debounce.sv */
`timescale 1ns / 1ps
`default_nettype none

module kpsd_debounce (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              enable,
	input  wire kpsd_pkg::code_t   code,
	input  wire kpsd_pkg::count_t  threshold,
	output kpsd_pkg::code_t        event_code,
	output kpsd_pkg::deb_status_t  status
);
	import kpsd_pkg::*;

	logic   release_q, release_d;
	count_t tick_q, tick_d;
	code_t  held_q, held_d;
	count_t tick_inc;
	logic   key_seen;

	assign tick_inc = tick_q + 8'd1;
	assign key_seen = (code != CODE_NONE);

	always_comb begin
		release_d  = release_q;
		tick_d     = tick_q;
		held_d     = held_q;
		event_code = CODE_NONE;
		if (!release_q) begin
			// A zero code in the press phase leaves everything as it is.
			if (tick_q == '0) begin
				if (key_seen) begin
					tick_d = 8'd1;
				end
			end else if (key_seen) begin
				held_d = code;
				tick_d = tick_inc;
				if (tick_inc >= threshold) begin
					tick_d    = '0;
					release_d = 1'b1;
				end
			end
		end else begin
			if (!key_seen) begin
				tick_d = tick_inc;
				if (tick_inc >= threshold) begin
					tick_d     = '0;
					release_d  = 1'b0;
					event_code = held_q;
				end
			end else begin
				tick_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= 1'b0;
			tick_q    <= '0;
			held_q    <= CODE_NONE;
		end else if (enable) begin
			release_q <= release_d;
			tick_q    <= tick_d;
			held_q    <= held_d;
		end
	end

	assign status.release_phase = release_q;
	assign status.tick_count    = tick_q;

endmodule

`default_nettype wire

/* sv/keypad_scan_debounce_core.sv */
// Matrix keypad scanner with press and release debounce.
//
// Input channel (in_valid, in_stall): one transfer per scan tick, carrying the
// column senses with all rows driven low and with each single row driven low.
// Output channel (out_valid, out_stall): exactly one transfer per input tick;
// key_event holds the released key code, or 0 when the tick confirmed nothing.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the debounce
// threshold; cfg_ready is always high. Write it only while the block is idle.
//
// An input transfer first lands in the input register, then decode and the
// debounce update write its result into the output register.
// Throughput is one item per cycle while the receiver does not stall; the
// debounce state register closes its update loop on every tick that moves on.
// When the receiver stalls, the result is held, the input register fills and
// in_stall rises; no tick is dropped or repeated.
// Reset clears both pipeline valids, the debounce state, and sets the
// threshold to 3.
`timescale 1ns / 1ps
`default_nettype none

module keypad_scan_debounce_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  idle_sense,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  row0_sense,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  row1_sense,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  row2_sense,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  row3_sense,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  row4_sense,
	input  wire logic [kpsd_pkg::SENSE_W-1:0]  row5_sense,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [kpsd_pkg::CODE_W-1:0]        key_event,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [kpsd_pkg::COUNT_W-1:0]  cfg_data
);
	import kpsd_pkg::*;

	count_t               debounce_q;
	logic                 valid_s1;
	logic [SENSE_W-1:0]   idle_s1;
	row_sense_t           rows_s1;
	logic                 advance;
	logic                 take_in;
	code_t                code;
	code_t                event_code;
	deb_status_t          status;
	logic                 out_valid_s2;
	code_t                key_event_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_q <= cfg_data;
		end
	end

	// The stage moves on whenever the output register is empty or drains.
	assign advance  = !out_valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			idle_s1 <= idle_sense;
			rows_s1 <= {row5_sense, row4_sense, row3_sense,
				row2_sense, row1_sense, row0_sense};
		end
	end

	kpsd_decode u_decode (
		.idle_sense (idle_s1),
		.row_sense  (rows_s1),
		.code       (code)
	);

	kpsd_debounce u_debounce (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (valid_s1 && advance),
		.code       (code),
		.threshold  (debounce_q),
		.event_code (event_code),
		.status     (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			key_event_s2 <= event_code;
		end
	end

	assign out_valid = out_valid_s2;
	assign key_event = key_event_s2;

	a_stall_only_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_s2 && out_stall))
		else $error("input stalled without a full pipeline");

	a_code_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_event <= CODE_MAX))
		else $error("key event out of range");

	a_event_ends_release : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_event != CODE_NONE) |-> !status.release_phase)
		else $error("event delivered while still in the release phase");

	a_release_seen_before_event : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && event_code != CODE_NONE) |-> status.release_phase)
		else $error("event produced outside the release phase");

endmodule

`default_nettype wire

/* tb/keypad_scan_debounce_core_tb.sv */
`timescale 1ns / 1ps

module keypad_scan_debounce_core_tb;
	import kpsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_TICKS    = 180;
	localparam int DIR_N          = 22;
	localparam int N_SETTINGS     = 7;

	typedef struct packed {
		logic [SENSE_W-1:0] idle;
		row_sense_t         rows;
	} scan_t;

	typedef struct packed {
		logic [SENSE_W-1:0] idle;
		row_sense_t         rows;
		logic               typed;
		code_t              want;
	} scan_row_t;

	// Keystrokes at the reset threshold of 3: plain presses, a release bounce,
	// a zero code inside the press count, several low columns, no row low.
	localparam scan_row_t DIR_TAB [DIR_N] = '{
		'{SENSE_NONE, 24'hFFFFFF, 1'b1, CODE_NONE},
		'{4'h0,       24'h000000, 1'b1, CODE_NONE},
		'{SENSE_COL0, 24'h0FFFFF, 1'b0, CODE_NONE},
		'{SENSE_COL3, 24'hFFFFFF, 1'b1, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b1, 5'd18},
		'{SENSE_COL3, 24'h0FFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'h000000, 1'b0, CODE_NONE},
		'{SENSE_COL3, 24'h0FFFFF, 1'b0, CODE_NONE},
		'{SENSE_COL3, 24'h0FFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_COL2, 24'hFFFFF0, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b1, CODE_MAX},
		'{4'hC,       24'hFFF5FF, 1'b0, CODE_NONE},
		'{SENSE_COL1, 24'hFFFFF0, 1'b0, CODE_NONE},
		'{SENSE_COL1, 24'h000000, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b0, CODE_NONE},
		'{SENSE_NONE, 24'hFFFFFF, 1'b1, 5'd7}
	};

	localparam count_t THRESH_LIST [N_SETTINGS] = '{
		8'd1, 8'd0, 8'd255, 8'd2, 8'd5, 8'd7, 8'd4
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [SENSE_W-1:0] idle_sense;
	logic [SENSE_W-1:0] row0_sense;
	logic [SENSE_W-1:0] row1_sense;
	logic [SENSE_W-1:0] row2_sense;
	logic [SENSE_W-1:0] row3_sense;
	logic [SENSE_W-1:0] row4_sense;
	logic [SENSE_W-1:0] row5_sense;
	logic               out_valid;
	logic               out_stall;
	code_t              key_event;
	logic               cfg_valid;
	logic               cfg_ready;
	count_t             cfg_data;

	// Local copy of the debounce state and threshold.
	logic   kp_release;
	count_t kp_count;
	code_t  kp_held;
	count_t kp_thresh;

	code_t pending_events [$];
	int    ticks_sent;
	int    mismatches;
	int    quiet_cycles;
	bit    idle_on;
	bit    hold_req;

	keypad_scan_debounce_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.idle_sense (idle_sense),
		.row0_sense (row0_sense),
		.row1_sense (row1_sense),
		.row2_sense (row2_sense),
		.row3_sense (row3_sense),
		.row4_sense (row4_sense),
		.row5_sense (row5_sense),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_event  (key_event),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic code_t decode_scan(input scan_t s);
		logic [1:0] col;
		int         row_num;
		int         i;
		logic [7:0] code;
		if (s.idle == SENSE_NONE)
			return CODE_NONE;
		case (s.idle)
			SENSE_COL1: col = 2'd1;
			SENSE_COL2: col = 2'd2;
			SENSE_COL3: col = 2'd3;
			default:    col = 2'd0;
		endcase
		row_num = 0;
		for (i = 0; i < ROWS; i++)
			if (row_num == 0 && s.rows[i] != SENSE_NONE)
				row_num = i + 1;
		code = 8'(col * ROWS + row_num);
		return code[CODE_W-1:0];
	endfunction

	function automatic code_t debounce_tick(input code_t code);
		code_t released;
		released = CODE_NONE;
		if (!kp_release) begin
			if (kp_count == 0) begin
				if (code != CODE_NONE)
					kp_count = 8'd1;
			end else if (code != CODE_NONE) begin
				kp_held  = code;
				kp_count = kp_count + 8'd1;
				if (kp_count >= kp_thresh) begin
					kp_count   = '0;
					kp_release = 1'b1;
				end
			end
		end else if (code == CODE_NONE) begin
			kp_count = kp_count + 8'd1;
			if (kp_count >= kp_thresh) begin
				kp_count   = '0;
				kp_release = 1'b0;
				released   = kp_held;
			end
		end else begin
			kp_count = '0;
		end
		return released;
	endfunction

	function automatic scan_t quiet_scan();
		scan_t s;
		s.idle = SENSE_NONE;
		s.rows = row_sense_t'($urandom());
		return s;
	endfunction

	function automatic scan_t noise_scan();
		scan_t s;
		s = scan_t'($urandom());
		return s;
	endfunction

	// A held key: one low column (or several), rows ahead of the key read high.
	function automatic scan_t key_scan(input int col, input int row_num, input bit multi);
		scan_t s;
		int    r;
		int    i;
		r = row_num;
		s.rows = row_sense_t'($urandom());
		case (col)
			1:       s.idle = SENSE_COL1;
			2:       s.idle = SENSE_COL2;
			3:       s.idle = SENSE_COL3;
			default: s.idle = SENSE_COL0;
		endcase
		if (multi) begin
			do
				s.idle = SENSE_W'($urandom_range(0, 15));
			while ($countones(s.idle) > 2);
		end
		if ((multi || col == 0) && r == 0)
			r = 1;
		for (i = 0; i < ROWS; i++) begin
			if (r == 0 || i < r - 1)
				s.rows[i] = SENSE_NONE;
			else if (i == r - 1)
				s.rows[i] = SENSE_W'($urandom_range(0, 14));
		end
		return s;
	endfunction

	task automatic send_scan(input scan_t s, input bit typed, input code_t want);
		int    gap;
		code_t released;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		idle_sense <= s.idle;
		row0_sense <= s.rows[0];
		row1_sense <= s.rows[1];
		row2_sense <= s.rows[2];
		row3_sense <= s.rows[3];
		row4_sense <= s.rows[4];
		row5_sense <= s.rows[5];
		do
			@(posedge clk);
		while (in_stall);
		released = debounce_tick(decode_scan(s));
		pending_events.push_back(typed ? want : released);
		ticks_sent++;
	endtask

	task automatic play_keystroke();
		int col;
		int row_num;
		int n;
		bit multi;
		col     = $urandom_range(0, 3);
		row_num = $urandom_range(0, ROWS);
		multi   = ($urandom_range(0, 7) == 0);
		while (!kp_release) begin
			if ($urandom_range(0, 5) == 0) begin
				send_scan(quiet_scan(), 1'b0, CODE_NONE);
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					col     = $urandom_range(0, 3);
					row_num = $urandom_range(0, ROWS);
				end
				send_scan(key_scan(col, row_num, multi), 1'b0, CODE_NONE);
			end
		end
		while (kp_release) begin
			if (kp_thresh <= 16 && $urandom_range(0, 9) == 0)
				send_scan(key_scan(col, row_num, multi), 1'b0, CODE_NONE);
			else
				send_scan(quiet_scan(), 1'b0, CODE_NONE);
		end
		n = $urandom_range(0, 2);
		repeat (n) send_scan(quiet_scan(), 1'b0, CODE_NONE);
	endtask

	task automatic run_phase(input int budget);
		int start;
		int n;
		start = ticks_sent;
		do begin
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				repeat (n) send_scan(noise_scan(), 1'b0, CODE_NONE);
			end else begin
				play_keystroke();
			end
		end while (ticks_sent - start < budget);
	endtask

	// Drops valid in the step of the last transfer, then waits for the
	// pipeline to empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input count_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		kp_thresh = value;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int    i;
		int    ph;
		scan_t s;
		arst_n     = 1'b0;
		clk        = 1'b0;
		in_valid   = 1'b0;
		idle_sense = SENSE_NONE;
		row0_sense = SENSE_NONE;
		row1_sense = SENSE_NONE;
		row2_sense = SENSE_NONE;
		row3_sense = SENSE_NONE;
		row4_sense = SENSE_NONE;
		row5_sense = SENSE_NONE;
		out_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		kp_release = 1'b0;
		kp_count   = '0;
		kp_held    = CODE_NONE;
		kp_thresh  = DEBOUNCE_RESET;
		ticks_sent = 0;
		mismatches = 0;
		idle_on    = 1'b1;
		hold_req   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++) begin
			s.idle = DIR_TAB[i].idle;
			s.rows = DIR_TAB[i].rows;
			send_scan(s, DIR_TAB[i].typed, DIR_TAB[i].want);
		end
		run_phase(PHASE_TICKS);

		for (ph = 0; ph < N_SETTINGS; ph++) begin
			settle();
			idle_on = (ph % 3) != 2;
			write_threshold(THRESH_LIST[ph]);
			if (ph == 0)
				hold_req = 1'b1;
			if (THRESH_LIST[ph] > 16)
				play_keystroke();
			else
				run_phase(PHASE_TICKS);
		end
		settle();

		if (pending_events.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("keypad_scan_debounce_core_tb OK");
		else
			$display("keypad_scan_debounce_core_tb NOT OK");
		$finish;
	end

	// Receiver side: random stalls per transfer, and one long hold that lets the
	// block fill up and stall its input.
	initial begin
		int    wait_n;
		code_t want;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				wait_n   = HOLD_CYCLES;
			end else begin
				wait_n = idle_on ? $urandom_range(0, 3) : 0;
			end
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_valid);
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected key_event transfer: got %0d", key_event);
			end else begin
				want = pending_events.pop_front();
				if (key_event !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("key_event mismatch: expected %0d, got %0d", want, key_event);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("keypad_scan_debounce_core_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

endmodule

/* keypad_scan_debounce_core.f */
sv/kpsd_pkg.sv
sv/kpsd_decode.sv
sv/kpsd_debounce.sv
sv/keypad_scan_debounce_core.sv
tb/keypad_scan_debounce_core_tb.sv
